// ===== rtl/bcwm_pkg.sv =====
// Shared types and constants of the byte class window matcher.
// No dependencies; every other file imports this package.
package bcwm_pkg;

  // Sizing of the pattern table and the offset counter
  localparam int MaxPatternLen = 16;
  localparam int RangesPerPos  = 8;
  localparam int OffsetBits    = 16;

  localparam int TableDepth = MaxPatternLen * RangesPerPos;
  localparam int TableAw    = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int WinAw      = (MaxPatternLen > 1) ? $clog2(MaxPatternLen) : 1;
  localparam int LenW       = 5;
  localparam int CntW       = OffsetBits + 1;

  // Fixed field widths of the ports
  localparam int PosW    = 4;
  localparam int SlotW   = 3;
  localparam int ByteW   = 8;
  localparam int OfsOutW = 16;
  localparam int CountW  = 16;

  // Request codes
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqData = 1'b1;

  typedef logic [MaxPatternLen-1:0][ByteW-1:0] win_t;

  // One input word as held in the input register
  typedef struct packed {
    logic             req_type;
    logic [PosW-1:0]  position;
    logic [SlotW-1:0] slot;
    logic             slot_valid;
    logic [ByteW-1:0] range_low;
    logic [ByteW-1:0] range_high;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } item_t;

  // One result word
  typedef struct packed {
    logic              match;
    logic [OfsOutW-1:0] match_offset;
    logic [CountW-1:0] match_count;
    logic              no_pattern;
    logic              offset_overflow;
    logic              end_of_buffer;
  } result_t;

endpackage

// ===== rtl/byte_class_window_matcher_unit.sv =====
// Top level of the byte class window matcher: input register, range table,
// scan logic and result register. Depends on bcwm_pkg, bcwm_range_table, bcwm_scan.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per cycle while
//   in_stall_o is low: a load (req_type 0) writes one range slot of the pattern
//   table, a data word (req_type 1) shifts data_byte into the match window.
//   Output channel (out_valid_o / out_stall_i) returns at most one result per
//   data word; loads give none, and data words before the window fills give
//   none unless pattern_len is zero or the word carries the last-byte mark.
//   Config channel (cfg_valid_i / cfg_ready_o) writes pattern_len; write it
//   only while the block is idle. cfg_ready_o is always high.
// Path: input register, then result register; a stalled result holds the next
//   word in between. Throughput: one word per cycle unless a result stalls; the
//   range compares of all positions sit in one stage between those registers.
// Reset: window, offset and match counters clear, all table slots become
//   invalid, pattern_len returns to zero.
// Stall: a stalled result holds; the input register still takes one more word,
//   and in_stall_o rises only when that register is full behind a stalled result.
module byte_class_window_matcher_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bcwm_pkg::LenW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [bcwm_pkg::PosW-1:0]        position_i,
  input  logic [bcwm_pkg::SlotW-1:0]       slot_i,
  input  logic                             slot_valid_i,
  input  logic [bcwm_pkg::ByteW-1:0]       range_low_i,
  input  logic [bcwm_pkg::ByteW-1:0]       range_high_i,
  input  logic [bcwm_pkg::ByteW-1:0]       data_byte_i,
  input  logic                             last_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             match_o,
  output logic [bcwm_pkg::OfsOutW-1:0]     match_offset_o,
  output logic [bcwm_pkg::CountW-1:0]      match_count_o,
  output logic                             no_pattern_o,
  output logic                             offset_overflow_o,
  output logic                             end_of_buffer_o
);
  import bcwm_pkg::*;

  logic [LenW-1:0]          len_q;
  item_t                    item_q;
  logic                     item_vld_q, item_vld_d;
  logic                     out_vld_q, out_vld_d;
  result_t                  res_q, res_d;
  logic                     in_acc, out_free, adv, step, load, emit;
  win_t                     pos_byte;
  logic [MaxPatternLen-1:0] pos_hit;

  // Config register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      len_q <= cfg_data_i;
    end
  end

  // Handshake: advance the input register when the result register is free
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = item_vld_q && out_free;
  assign in_stall_o = item_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign step       = adv && (item_q.req_type == ReqData);
  assign load       = adv && (item_q.req_type == ReqLoad);

  always_comb begin
    item_vld_d = item_vld_q;
    if (in_acc) begin
      item_vld_d = 1'b1;
    end else if (adv) begin
      item_vld_d = 1'b0;
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.req_type   <= req_type_i;
      item_q.position   <= position_i;
      item_q.slot       <= slot_i;
      item_q.slot_valid <= slot_valid_i;
      item_q.range_low  <= range_low_i;
      item_q.range_high <= range_high_i;
      item_q.data_byte  <= data_byte_i;
      item_q.last_byte  <= last_byte_i;
    end
  end

  bcwm_range_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (load),
    .wr_pos_i   (item_q.position),
    .wr_slot_i  (item_q.slot),
    .wr_valid_i (item_q.slot_valid),
    .wr_low_i   (item_q.range_low),
    .wr_high_i  (item_q.range_high),
    .pos_byte_i (pos_byte),
    .pos_hit_o  (pos_hit)
  );

  bcwm_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (item_q.data_byte),
    .last_byte_i   (item_q.last_byte),
    .pattern_len_i (len_q),
    .pos_hit_i     (pos_hit),
    .pos_byte_o    (pos_byte),
    .emit_o        (emit),
    .result_o      (res_d)
  );

  // Result register: refill or drain whenever it is free
  assign out_vld_d = out_free ? (step && emit) : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign match_o           = res_q.match;
  assign match_offset_o    = res_q.match_offset;
  assign match_count_o     = res_q.match_count;
  assign no_pattern_o      = res_q.no_pattern;
  assign offset_overflow_o = res_q.offset_overflow;
  assign end_of_buffer_o   = res_q.end_of_buffer;

  // Without a pattern nothing can match
  a_no_pattern_no_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_pattern_o |-> !match_o)
    else $error("match reported with no pattern");

  // Input backs up only behind a stalled result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

  // A match always shows a nonzero running count
  a_match_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_o |-> (match_count_o != '0))
    else $error("match with zero count");

endmodule

// ===== rtl/bcwm_range_table.sv =====
// Range slot table with one set of range compares per pattern position.
// Depends on bcwm_pkg.
module bcwm_range_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [bcwm_pkg::PosW-1:0]         wr_pos_i,
  input  logic [bcwm_pkg::SlotW-1:0]        wr_slot_i,
  input  logic                              wr_valid_i,
  input  logic [bcwm_pkg::ByteW-1:0]        wr_low_i,
  input  logic [bcwm_pkg::ByteW-1:0]        wr_high_i,
  input  bcwm_pkg::win_t                    pos_byte_i,
  output logic [bcwm_pkg::MaxPatternLen-1:0] pos_hit_o
);
  import bcwm_pkg::*;

  logic [TableDepth-1:0] valid_q;
  logic [ByteW-1:0]      low_q  [TableDepth];
  logic [ByteW-1:0]      high_q [TableDepth];
  logic                  wr_ok;
  logic [TableAw-1:0]    wr_idx;

  // Drop loads that fall outside the table
  assign wr_ok  = wr_en_i && (int'(wr_pos_i) < MaxPatternLen) &&
                  (int'(wr_slot_i) < RangesPerPos);
  assign wr_idx = TableAw'(int'(wr_pos_i) * RangesPerPos + int'(wr_slot_i));

  // Slot valid bits clear at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_ok) begin
      valid_q[wr_idx] <= wr_valid_i;
    end
  end

  // Range bounds
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      low_q[wr_idx]  <= wr_low_i;
      high_q[wr_idx] <= wr_high_i;
    end
  end

  // A position hits when any valid slot covers its byte
  always_comb begin
    pos_hit_o = '0;
    for (int p = 0; p < MaxPatternLen; p++) begin
      for (int s = 0; s < RangesPerPos; s++) begin
        if (valid_q[p*RangesPerPos+s] &&
            (low_q[p*RangesPerPos+s] <= pos_byte_i[p]) &&
            (pos_byte_i[p] <= high_q[p*RangesPerPos+s])) begin
          pos_hit_o[p] = 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/bcwm_scan.sv =====
// Byte window, offset and match counters, and result formation.
// Depends on bcwm_pkg; takes per-position hits from bcwm_range_table.
module bcwm_scan (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic [bcwm_pkg::ByteW-1:0]         data_byte_i,
  input  logic                               last_byte_i,
  input  logic [bcwm_pkg::LenW-1:0]          pattern_len_i,
  input  logic [bcwm_pkg::MaxPatternLen-1:0] pos_hit_i,
  output bcwm_pkg::win_t                     pos_byte_o,
  output logic                               emit_o,
  output bcwm_pkg::result_t                  result_o
);
  import bcwm_pkg::*;

  win_t              win_q, win_d, win_new;
  logic [CntW-1:0]   off_q, off_d;
  logic [CountW-1:0] total_q, total_d, total_upd;
  logic [LenW-1:0]   len;
  logic [LenW-1:0]   tap;
  logic [CntW-1:0]   len_m1;
  logic              ovf, len_zero, full, all_hit, hit;
  logic [CntW-1:0]   off_full;

  // Shift the new byte in, newest at index zero
  always_comb begin
    win_new[0] = data_byte_i;
    for (int i = 1; i < MaxPatternLen; i++) begin
      win_new[i] = win_q[i-1];
    end
  end

  // Clamp the length to the table size
  assign len = (int'(pattern_len_i) > MaxPatternLen) ? LenW'(MaxPatternLen) : pattern_len_i;
  assign len_zero = (len == '0);
  assign len_m1   = CntW'(len) - CntW'(1);

  // Route each position its byte: position p sees age len-1-p
  always_comb begin
    for (int p = 0; p < MaxPatternLen; p++) begin
      tap = len - LenW'(1) - LenW'(p);
      pos_byte_o[p] = (LenW'(p) < len) ? win_new[tap[WinAw-1:0]] : '0;
    end
  end

  // Window match over positions in use
  always_comb begin
    all_hit = 1'b1;
    for (int p = 0; p < MaxPatternLen; p++) begin
      if ((LenW'(p) < len) && !pos_hit_i[p]) begin
        all_hit = 1'b0;
      end
    end
  end

  assign ovf       = off_q[OffsetBits];
  assign full      = !len_zero && (off_q >= len_m1);
  assign hit       = full && all_hit;
  assign emit_o    = len_zero || full || last_byte_i;
  assign total_upd = (hit && (total_q != '1)) ? total_q + CountW'(1) : total_q;
  assign off_full  = ovf ? CntW'({OffsetBits{1'b1}}) : off_q - len_m1;

  // Form the result word
  always_comb begin
    result_o.match           = hit;
    result_o.match_offset    = hit ? OfsOutW'(off_full) : '0;
    result_o.match_count     = total_upd;
    result_o.no_pattern      = len_zero;
    result_o.offset_overflow = ovf;
    result_o.end_of_buffer   = last_byte_i;
  end

  // Advance on each data byte; clear after a last byte
  always_comb begin
    win_d   = win_q;
    off_d   = off_q;
    total_d = total_q;
    if (step_i) begin
      if (last_byte_i) begin
        win_d   = '0;
        off_d   = '0;
        total_d = '0;
      end else begin
        win_d   = win_new;
        off_d   = ovf ? off_q : off_q + CntW'(1);
        total_d = total_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      off_q   <= '0;
      total_q <= '0;
    end else begin
      win_q   <= win_d;
      off_q   <= off_d;
      total_q <= total_d;
    end
  end

endmodule
